// ----- rtl/mlgm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message latency and gap monitor package
// Shared widths, latency limits, controller states and the latency
// saturation function.
// ----------------------------------------------------------------------------
package mlgm_pkg;

  localparam int LAT_W  = 48;
  localparam int SEQ_W  = 64;
  localparam int TIME_W = 63;
  localparam int BYTE_W = 32;
  localparam int CNT_W  = 64;

  localparam logic [LAT_W-1:0] LAT_MAX = {1'b0, {(LAT_W-1){1'b1}}};
  localparam logic [LAT_W-1:0] LAT_MIN = {1'b1, {(LAT_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ADD,
    ST_PREP,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_e;

  // Latency is arrival minus send, clamped to the signed 48-bit range.
  function automatic logic [LAT_W-1:0] sat_latency(input logic [TIME_W-1:0] arrived,
                                                   input logic [TIME_W-1:0] sent);
    logic [TIME_W:0] diff;
    logic [TIME_W:0] diff_ext;
    diff     = {1'b0, arrived} - {1'b0, sent};
    diff_ext = {{(TIME_W+1-LAT_W){diff[LAT_W-1]}}, diff[LAT_W-1:0]};
    if (diff == diff_ext) begin
      return diff[LAT_W-1:0];
    end else if (diff[TIME_W]) begin
      return LAT_MIN;
    end else begin
      return LAT_MAX;
    end
  endfunction

endpackage

// ----- rtl/mlgm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module mlgm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 100
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/message_latency_and_gap_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message latency and gap monitor
// Tracks latency extremes, a moving average over the last WINDOW latencies,
// and message, byte and dropped-sequence counters for a stream of headers.
// ----------------------------------------------------------------------------
//  Channel | Handshake               | Payload
//  --------+-------------------------+-------------------------------------------
//  in      | in_valid_i / in_ready_o | sequence_number, send_time, arrival_time,
//          |                         | payload_bytes
//  out     | out_valid_o/out_ready_i | accepted, latency_average/maximum/minimum,
//          |                         | message_count, byte_count, dropped_count
//
//  A newer message passes through the read, add, prepare, divide, finish and
//  output states; a bit-serial divider forms the average from the window sum,
//  SW = 48 + clog2(WINDOW + 1) bits wide. A stale message skips to ST_OUT.
//  One message is in flight at a time. The latency ring needs no clearing pass;
//  reset clears the control state and statistics but not the data registers.
//  A new transfer is taken while a finished result still waits on the output.
// ----------------------------------------------------------------------------
module message_latency_and_gap_monitor #(
  parameter int WINDOW = 100
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mlgm_pkg::SEQ_W-1:0]   sequence_number_i,
  input  logic [mlgm_pkg::TIME_W-1:0]  send_time_i,
  input  logic [mlgm_pkg::TIME_W-1:0]  arrival_time_i,
  input  logic [mlgm_pkg::BYTE_W-1:0]  payload_bytes_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         accepted_o,
  output logic signed [mlgm_pkg::LAT_W-1:0] latency_average_o,
  output logic signed [mlgm_pkg::LAT_W-1:0] latency_maximum_o,
  output logic signed [mlgm_pkg::LAT_W-1:0] latency_minimum_o,
  output logic [mlgm_pkg::CNT_W-1:0]   message_count_o,
  output logic [mlgm_pkg::CNT_W-1:0]   byte_count_o,
  output logic [mlgm_pkg::CNT_W-1:0]   dropped_count_o
);

  import mlgm_pkg::*;

  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FW = $clog2(WINDOW + 1);
  localparam int SW = LAT_W + $clog2(WINDOW + 1);
  localparam int CW = $clog2(SW + 1);

  localparam logic [IW-1:0] HEAD_LAST = IW'(WINDOW - 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(WINDOW);

  state_e state_q, state_d;

  logic              in_fire;
  logic              ram_re;
  logic              ram_we;
  logic              out_load;
  logic [LAT_W-1:0]  ram_rdata;
  logic              full;

  logic [SEQ_W-1:0]  seq_q, seq_d;
  logic [TIME_W-1:0] send_q, send_d;
  logic [TIME_W-1:0] arr_q, arr_d;
  logic [BYTE_W-1:0] bytes_q, bytes_d;
  logic              acc_q, acc_d;
  logic [LAT_W-1:0]  lat_q, lat_d;
  logic [CNT_W-1:0]  gap_q, gap_d;

  logic [SEQ_W-1:0]  last_q, last_d;
  logic [IW-1:0]     head_q, head_d;
  logic [FW-1:0]     fill_q, fill_d;
  logic [SW-1:0]     sum_q, sum_d;
  logic [LAT_W-1:0]  max_q, max_d;
  logic [LAT_W-1:0]  min_q, min_d;
  logic [LAT_W-1:0]  avg_q, avg_d;
  logic [CNT_W-1:0]  msgs_q, msgs_d;
  logic [CNT_W-1:0]  byts_q, byts_d;
  logic [CNT_W-1:0]  drops_q, drops_d;

  logic [SW-1:0]     quo_q, quo_d;
  logic [FW-1:0]     rem_q, rem_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              neg_q, neg_d;
  logic [FW:0]       trial;
  logic              trial_ge;

  logic              out_valid_q, out_valid_d;
  logic              out_acc_q;
  logic [LAT_W-1:0]  out_avg_q, out_max_q, out_min_q;
  logic [CNT_W-1:0]  out_msgs_q, out_byts_q, out_drops_q;

  assign in_fire  = in_valid_i && in_ready_o;
  assign full     = (fill_q == FILL_FULL);
  assign trial    = {rem_q, quo_q[SW-1]};
  assign trial_ge = (trial >= {1'b0, fill_q});

  mlgm_ram #(
    .WIDTH (LAT_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_q),
    .wdata_i (lat_q),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (sequence_number_i > last_q) ? ST_READ : ST_OUT;
        end
      end
      ST_READ: state_d = ST_ADD;
      ST_ADD:  state_d = ST_PREP;
      ST_PREP: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == CW'(1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ram_re     = in_valid_i;
      end
      ST_ADD:  ram_we   = 1'b1;
      ST_OUT:  out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_comb begin
    seq_d   = seq_q;
    send_d  = send_q;
    arr_d   = arr_q;
    bytes_d = bytes_q;
    acc_d   = acc_q;
    lat_d   = lat_q;
    gap_d   = gap_q;
    last_d  = last_q;
    head_d  = head_q;
    fill_d  = fill_q;
    sum_d   = sum_q;
    max_d   = max_q;
    min_d   = min_q;
    avg_d   = avg_q;
    msgs_d  = msgs_q;
    byts_d  = byts_q;
    drops_d = drops_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          seq_d   = sequence_number_i;
          send_d  = send_time_i;
          arr_d   = arrival_time_i;
          bytes_d = payload_bytes_i;
          acc_d   = (sequence_number_i > last_q);
        end
      end
      ST_READ: begin
        lat_d = sat_latency(arr_q, send_q);
        // seq + ~last equals seq - last - 1 modulo 2^64.
        gap_d = (last_q != '0) ? (seq_q + ~last_q) : '0;
        if (full) begin
          sum_d = sum_q - {{(SW-LAT_W){ram_rdata[LAT_W-1]}}, ram_rdata};
        end
      end
      ST_ADD: begin
        sum_d = sum_q + {{(SW-LAT_W){lat_q[LAT_W-1]}}, lat_q};
        if ($signed(lat_q) > $signed(max_q)) begin
          max_d = lat_q;
        end
        if ($signed(lat_q) < $signed(min_q)) begin
          min_d = lat_q;
        end
        head_d = (head_q == HEAD_LAST) ? '0 : head_q + IW'(1);
        if (!full) begin
          fill_d = fill_q + FW'(1);
        end
        msgs_d  = msgs_q + CNT_W'(1);
        byts_d  = byts_q + CNT_W'(bytes_q);
        drops_d = drops_q + gap_q;
        last_d  = seq_q;
      end
      ST_PREP: begin
        neg_d = sum_q[SW-1];
        quo_d = sum_q[SW-1] ? -sum_q : sum_q;
        rem_d = '0;
        cnt_d = CW'(SW);
      end
      ST_DIV: begin
        rem_d = trial_ge ? FW'(trial - {1'b0, fill_q}) : trial[FW-1:0];
        quo_d = {quo_q[SW-2:0], trial_ge};
        cnt_d = cnt_q - CW'(1);
      end
      ST_FIN: begin
        avg_d = neg_q ? -quo_q[LAT_W-1:0] : quo_q[LAT_W-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      last_q      <= '0;
      head_q      <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      max_q       <= '0;
      min_q       <= LAT_MAX;
      avg_q       <= '0;
      msgs_q      <= '0;
      byts_q      <= '0;
      drops_q     <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      max_q       <= max_d;
      min_q       <= min_d;
      avg_q       <= avg_d;
      msgs_q      <= msgs_d;
      byts_q      <= byts_d;
      drops_q     <= drops_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q   <= seq_d;
    send_q  <= send_d;
    arr_q   <= arr_d;
    bytes_q <= bytes_d;
    acc_q   <= acc_d;
    lat_q   <= lat_d;
    gap_q   <= gap_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    neg_q   <= neg_d;
    if (out_load) begin
      out_acc_q   <= acc_q;
      out_avg_q   <= avg_q;
      out_max_q   <= max_q;
      out_min_q   <= min_q;
      out_msgs_q  <= msgs_q;
      out_byts_q  <= byts_q;
      out_drops_q <= drops_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = out_acc_q;
  assign latency_average_o = out_avg_q;
  assign latency_maximum_o = out_max_q;
  assign latency_minimum_o = out_min_q;
  assign message_count_o   = out_msgs_q;
  assign byte_count_o      = out_byts_q;
  assign dropped_count_o   = out_drops_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_FULL)
    else $error("Window fill exceeds the window size.");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= HEAD_LAST)
    else $error("Ring head is outside the ring.");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msgs_q != '0 |-> $signed(min_q) <= $signed(max_q))
    else $error("Minimum latency exceeds maximum latency.");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < fill_q)
    else $error("Divider remainder is not below the divisor.");
`endif

endmodule
